FILE: rtl/core/swm_pkg.sv
// Package for the sliding window median filter.
// Holds the sequencer state type and the control word of the sorting cells.
// No dependencies.
`default_nettype none

package swm_pkg;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } swm_state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_DROP,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     head;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/swm_if.sv
// Valid/ready channel interfaces of the sliding window median filter.
// One carries the sample items in, the other the median items out; no dependencies.
`default_nettype none

interface swm_in_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_new;

    modport source (output valid, output sample, output start_new, input ready);
    modport sink   (input valid, input sample, input start_new, output ready);
endinterface

interface swm_out_if #(
    parameter int SAMPLE_BITS = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sliding_window_median.sv
// Top level of the sliding window median filter: sequencer, age FIFO and cell chain.
// Depends on swm_pkg, swm_if, swm_cell and swm_pick.
//
// The block keeps the last k samples (k from window_size, 0 read as 1, above MAX_WINDOW
// read as MAX_WINDOW) in a chain of sorting cells and gives the lower median once k
// samples of the current sequence have arrived. An item is accepted, each window entry
// that leaves the window is then removed in a step of its own, the item is inserted into
// the chain, and then its median is loaded into the output register in the cycle in which
// the next item may already be accepted; that load waits while the output register holds
// a result that is not taken. No item is accepted before then. After the window is shrunk
// the first item also removes each further entry. The sequencer sets the removal steps;
// the chain takes out one entry per cycle, its value read from the age FIFO memory.
`default_nettype none

module sliding_window_median
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wen,
    input  wire [6:0]   cfg_wdata,
    swm_in_if.sink      samples,
    swm_out_if.source   results
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int XW = (CW > 7) ? CW : 7;

    swm_state_t                    state_reg;
    swm_state_t                    state_next;
    logic [6:0]                    window_size_reg;
    logic [CW-1:0]                 fill_reg;
    logic [CW-1:0]                 fill_next;
    logic [PW-1:0]                 rd_ptr_reg;
    logic [PW-1:0]                 rd_ptr_next;
    logic [PW-1:0]                 wr_ptr_reg;
    logic [PW-1:0]                 wr_ptr_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic signed [SAMPLE_BITS-1:0] key_reg;
    logic signed [SAMPLE_BITS-1:0] key_next;
    logic signed [SAMPLE_BITS-1:0] median_reg;
    logic signed [SAMPLE_BITS-1:0] median_next;
    logic signed [SAMPLE_BITS-1:0] old_reg;
    logic [SAMPLE_BITS-1:0]        fifo_mem [MAX_WINDOW];

    logic [XW-1:0]                 ws_ext;
    logic [CW-1:0]                 k;
    logic                          slot_free;
    logic                          take_ok;
    logic                          accept;
    logic                          mem_we;
    logic [PW-1:0]                 rd_inc;
    logic [PW-1:0]                 wr_inc;
    cell_op_t                      cell_op;

    logic [MAX_WINDOW-1:0]                  cell_valid;
    logic [MAX_WINDOW-1:0][SAMPLE_BITS-1:0] cell_value;
    logic [MAX_WINDOW+1:0]                  ext_valid;
    logic [MAX_WINDOW+1:0][SAMPLE_BITS-1:0] ext_value;
    logic signed [SAMPLE_BITS-1:0]          pick_median;

    always_comb
    begin
        ws_ext = XW'(window_size_reg);
        if (ws_ext == '0)
        begin
            k = CW'(1);
        end
        else if (ws_ext > XW'(MAX_WINDOW))
        begin
            k = CW'(MAX_WINDOW);
        end
        else
        begin
            k = CW'(ws_ext);
        end
    end

    assign rd_inc    = (rd_ptr_reg == PW'(MAX_WINDOW - 1)) ? '0 : rd_ptr_reg + PW'(1);
    assign wr_inc    = (wr_ptr_reg == PW'(MAX_WINDOW - 1)) ? '0 : wr_ptr_reg + PW'(1);
    assign slot_free = !out_valid_reg || results.ready;
    assign take_ok   = (state_reg == ST_IDLE) || ((state_reg == ST_EMIT) && slot_free);
    assign accept    = samples.valid && take_ok;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        rd_ptr_next    = rd_ptr_reg;
        wr_ptr_next    = wr_ptr_reg;
        out_valid_next = out_valid_reg && !results.ready;
        key_next       = key_reg;
        median_next    = median_reg;
        mem_we         = 1'b0;
        cell_op        = OP_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
            end
            ST_RUN:
            begin
                if (fill_reg >= k)
                begin
                    cell_op     = OP_DROP;
                    rd_ptr_next = rd_inc;
                    fill_next   = fill_reg - CW'(1);
                end
                else
                begin
                    cell_op     = OP_INSERT;
                    mem_we      = 1'b1;
                    wr_ptr_next = wr_inc;
                    fill_next   = fill_reg + CW'(1);
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = (fill_reg >= k);
                    median_next    = pick_median;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (accept)
        begin
            key_next   = samples.sample;
            state_next = ST_RUN;
            if (samples.start_new)
            begin
                cell_op     = OP_CLEAR;
                fill_next   = '0;
                rd_ptr_next = wr_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_size_reg <= 7'd1;
            fill_reg        <= '0;
            rd_ptr_reg      <= '0;
            wr_ptr_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            rd_ptr_reg    <= rd_ptr_next;
            wr_ptr_reg    <= wr_ptr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                window_size_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        median_reg <= median_next;
    end

    // The oldest entry's value is kept ready for the next removal step.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fifo_mem[wr_ptr_reg] <= key_reg;
        end
        if (mem_we && (wr_ptr_reg == rd_ptr_next))
        begin
            old_reg <= key_reg;
        end
        else
        begin
            old_reg <= $signed(fifo_mem[rd_ptr_next]);
        end
    end

    assign ext_valid = {1'b0, cell_valid, 1'b0};
    assign ext_value = {{SAMPLE_BITS{1'b0}}, cell_value, {SAMPLE_BITS{1'b0}}};

    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        cell_ctrl_t                    ctrl;
        logic signed [SAMPLE_BITS-1:0] value_out;

        assign ctrl.op       = cell_op;
        assign ctrl.head     = (i == 0);
        assign cell_value[i] = value_out;

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .key         (key_reg),
            .old         (old_reg),
            .left_valid  (ext_valid[i]),
            .left_value  ($signed(ext_value[i])),
            .right_valid (ext_valid[i+2]),
            .right_value ($signed(ext_value[i+2])),
            .valid       (cell_valid[i]),
            .value       (value_out)
        );
    end

    swm_pick #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_pick (
        .clk    (clk),
        .rst_n  (rst_n),
        .k      (k),
        .values (cell_value),
        .median (pick_median)
    );

    assign samples.ready  = take_ok;
    assign results.valid  = out_valid_reg;
    assign results.median = median_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MAX_WINDOW))
        else $error("fill count beyond the chain length");

    a_fill_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == int'(fill_reg))
        else $error("valid cells disagree with the fill count");

    a_cells_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_valid & (cell_valid + MAX_WINDOW'(1))) == '0)
        else $error("valid cells do not form a prefix of the chain");

    a_emit_after_insert: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result item raised outside the emit step");

endmodule

`default_nettype wire

FILE: rtl/core/swm_cell.sv
// One cell of the sorted chain: holds one window entry and its valid flag.
// Depends on swm_pkg for the control word.
`default_nettype none

module swm_cell
    import swm_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire cell_ctrl_t               ctrl,
    input  wire logic signed [SAMPLE_BITS-1:0] key,
    input  wire logic signed [SAMPLE_BITS-1:0] old,
    input  wire                           left_valid,
    input  wire logic signed [SAMPLE_BITS-1:0] left_value,
    input  wire                           right_valid,
    input  wire logic signed [SAMPLE_BITS-1:0] right_value,
    output logic                          valid,
    output logic signed [SAMPLE_BITS-1:0] value
);

    logic                          valid_reg;
    logic                          valid_next;
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic signed [SAMPLE_BITS-1:0] value_next;
    logic                          left_gt;
    logic                          left_le;
    logic                          self_gt;

    always_comb
    begin
        left_gt    = left_valid && (left_value > key);
        left_le    = ctrl.head || (left_valid && !(left_value > key));
        self_gt    = !valid_reg || (value_reg > key);
        valid_next = valid_reg;
        value_next = value_reg;
        unique case (ctrl.op)
            OP_HOLD:
            begin
                valid_next = valid_reg;
            end
            OP_CLEAR:
            begin
                valid_next = 1'b0;
            end
            OP_DROP:
            begin
                if (valid_reg && (value_reg >= old))
                begin
                    valid_next = right_valid;
                    value_next = right_value;
                end
            end
            OP_INSERT:
            begin
                priority if (left_gt)
                begin
                    valid_next = left_valid;
                    value_next = left_value;
                end
                else if (left_le && self_gt)
                begin
                    valid_next = 1'b1;
                    value_next = key;
                end
                else
                begin
                    valid_next = valid_reg;
                end
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign valid = valid_reg;
    assign value = value_reg;

endmodule

`default_nettype wire

FILE: rtl/core/swm_pick.sv
// Median tap of the sorted chain: a registered one-hot tap at position (k-1)/2
// and an AND-OR select over the cell values. Depends on swm_pkg only by convention.
`default_nettype none

module swm_pick
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  wire                                         clk,
    input  wire                                         rst_n,
    input  wire [$clog2(MAX_WINDOW+1)-1:0]              k,
    input  wire [MAX_WINDOW-1:0][SAMPLE_BITS-1:0]       values,
    output logic signed [SAMPLE_BITS-1:0]               median
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int PW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [CW-1:0]          k_less;
    logic [PW-1:0]          tap_pos;
    logic [MAX_WINDOW-1:0]  tap_reg;
    logic [MAX_WINDOW-1:0]  tap_next;
    logic [SAMPLE_BITS-1:0] picked;

    always_comb
    begin
        k_less  = k - CW'(1);
        tap_pos = PW'(k_less >> 1);
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            tap_next[i] = (tap_pos == PW'(i));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else
        begin
            tap_reg <= tap_next;
        end
    end

    always_comb
    begin
        picked = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            picked = picked | (values[i] & {SAMPLE_BITS{tap_reg[i]}});
        end
    end

    assign median = $signed(picked);

endmodule

`default_nettype wire
